// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic                       kind;
        logic signed [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  removed_value;
        logic signed [VALUE_W-1:0]  top_value;
        logic [COUNT_W-1:0]         count;
        logic                       is_empty;
        logic                       is_full;
    } rsp_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                       ins_en;
        logic                       rem_en;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted store: compares against the new value, takes the
// new value, its left neighbor's entry or its right neighbor's entry, or keeps its own.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                                clk,
    input  spq_pkg::cell_ctl_t                  ctl,
    input  logic                                occupied,
    input  logic                                left_lt,
    input  logic signed [spq_pkg::VALUE_W-1:0]  left_entry,
    input  logic signed [spq_pkg::VALUE_W-1:0]  right_entry,
    output logic                                lt,
    output logic signed [spq_pkg::VALUE_W-1:0]  entry,
    output logic signed [spq_pkg::VALUE_W-1:0]  entry_next
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;

    // equal values stay ahead, so a new value lands after them
    assign lt = !occupied || (entry_reg < ctl.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins_en)
        begin
            if (left_lt)
            begin
                entry_next = left_entry;
            end
            else if (lt)
            begin
                entry_next = ctl.value;
            end
        end
        else if (ctl.rem_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded max-priority queue held as a descending row of cells.
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+--------------------------
//  request | req_valid | req_ready | req (kind, value)
//  result  | rsp_valid | rsp_ready | rsp (status ... is_full)
//
// One item per cycle while results are taken: all cells compare and shift in the cycle
// of acceptance, and the result sits in an output register the next cycle.
// A new item is taken whenever the output register is empty or being drained.
// Reset empties the queue; entry contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int CAPACITY = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  spq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output spq_pkg::rsp_t  rsp
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;
    logic                       rsp_valid_reg;
    rsp_t                       rsp_reg;
    rsp_t                       rsp_next;
    logic                       accept;
    logic                       full;
    logic                       empty;
    cell_ctl_t                  ctl;

    logic                       lt        [CAPACITY];
    logic signed [VALUE_W-1:0]  e         [CAPACITY];
    logic signed [VALUE_W-1:0]  e_next    [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (occ_reg >= OCC_W'(CAPACITY));
    assign empty     = (occ_reg == '0);

    assign ctl.ins_en = accept && (req.kind == KIND_INSERT) && !full;
    assign ctl.rem_en = accept && (req.kind == KIND_REMOVE) && !empty;
    assign ctl.value  = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                      left_lt;
        logic signed [VALUE_W-1:0] left_entry;
        logic signed [VALUE_W-1:0] right_entry;

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b0;
            assign left_entry = e[0];
        end
        else
        begin : g_mid
            assign left_lt    = lt[i-1];
            assign left_entry = e[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = e[i];
        end
        else
        begin : g_inner
            assign right_entry = e[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (OCC_W'(i) < occ_reg),
            .left_lt     (left_lt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .lt          (lt[i]),
            .entry       (e[i]),
            .entry_next  (e_next[i])
        );
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.ins_en)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctl.rem_en)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end

        rsp_next.status = ST_OK;
        if (req.kind == KIND_INSERT && full)
        begin
            rsp_next.status = ST_OVERFLOW;
        end
        else if (req.kind == KIND_REMOVE && empty)
        begin
            rsp_next.status = ST_UNDERFLOW;
        end
        rsp_next.removed_value = ctl.rem_en ? e[0] : '0;
        rsp_next.top_value     = (occ_next != '0) ? e_next[0] : '0;
        rsp_next.count         = COUNT_W'(occ_next);
        rsp_next.is_empty      = (occ_next == '0);
        rsp_next.is_full       = (occ_next == OCC_W'(CAPACITY));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_rsp_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item produced no result");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rem_en |=> (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("removal did not decrement occupancy");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg >= OCC_W'(2)) |-> (e[0] >= e[1]))
        else $error("head entry out of order");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue: a queue-fed driver offers
// insert and remove items, a clocked monitor compares every result with a
// descending-store model of the queue, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 8;
    localparam int RAND_ITEMS  = 1550;
    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 80;
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 1000;
    localparam int MAX_REPORTS = 10;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    // model of the queue contents, largest first
    logic signed [VALUE_W-1:0] model_vals [QUEUE_DEPTH];
    int unsigned               model_occ = 0;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    rsp_t pred_rsp;

    int unsigned items_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned error_cnt    = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned ok_cnt       = 0;
    int unsigned ovf_cnt      = 0;
    int unsigned unf_cnt      = 0;
    int unsigned peak_occ     = 0;

    sorted_priority_queue_top #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // apply one item to the model and build the result it should produce
    task automatic apply_queue_op(input req_t r, output rsp_t e);
        int unsigned pos;
        int unsigned i;
        begin
            e = '0;
            e.status = ST_OK;
            if (r.kind == KIND_INSERT)
            begin
                if (model_occ >= QUEUE_DEPTH)
                    e.status = ST_OVERFLOW;
                else
                begin
                    // equal values stay in arrival order
                    pos = 0;
                    while (pos < model_occ && model_vals[pos] >= r.value)
                        pos++;
                    for (i = model_occ; i > pos; i--)
                        model_vals[i] = model_vals[i-1];
                    model_vals[pos] = r.value;
                    model_occ++;
                end
            end
            else
            begin
                if (model_occ == 0)
                    e.status = ST_UNDERFLOW;
                else
                begin
                    e.removed_value = model_vals[0];
                    for (i = 0; i + 1 < model_occ; i++)
                        model_vals[i] = model_vals[i+1];
                    model_occ--;
                end
            end
            e.top_value = (model_occ > 0) ? model_vals[0] : '0;
            e.count     = COUNT_W'(model_occ);
            e.is_empty  = (model_occ == 0);
            e.is_full   = (model_occ == QUEUE_DEPTH);
            case (e.status)
                ST_OK:       ok_cnt++;
                ST_OVERFLOW: ovf_cnt++;
                default:     unf_cnt++;
            endcase
            if (model_occ > peak_occ)
                peak_occ = model_occ;
        end
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t e;
        bit   bad;
        begin
            if (expected_rsps.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: status %0d top %0d",
                             $realtime, got.status, got.top_value);
            end
            else
            begin
                e = expected_rsps.pop_front();
                bad = (got.status        !== e.status)        ||
                      (got.removed_value !== e.removed_value) ||
                      (got.top_value     !== e.top_value)     ||
                      (got.count         !== e.count)         ||
                      (got.is_empty      !== e.is_empty)      ||
                      (got.is_full       !== e.is_full);
                if (bad)
                begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                    begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("  expected st %0d rem %0d top %0d cnt %0d empty %0b full %0b",
                                 e.status, e.removed_value, e.top_value, e.count,
                                 e.is_empty, e.is_full);
                        $display("  actual   st %0d rem %0d top %0d cnt %0d empty %0b full %0b",
                                 got.status, got.removed_value, got.top_value, got.count,
                                 got.is_empty, got.is_full);
                    end
                end
            end
        end
    endtask

    function automatic bit src_idle();
        if (items_taken >= CALM_FROM && items_taken < CALM_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < 33);
    endfunction

    function automatic bit sink_idle();
        if (results_seen >= CALM_FROM && results_seen < CALM_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < 33);
    endfunction

    // mix of extremes, clustered small values for ties, and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2, 3, 4:
            begin
                v = $urandom_range(0, 15);
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic req_t make_req(input logic k, input logic signed [VALUE_W-1:0] v);
        req_t r;
        r.kind  = k;
        r.value = v;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                apply_queue_op(req, pred_rsp);
                expected_rsps.push_back(pred_rsp);
                items_taken++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && !src_idle())
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                check_result(rsp);
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (results_seen >= HOLD_AT && !hold_done)
            begin
                // long stall so the queue backs up into the request side
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= !sink_idle();
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_rsps.size());
            $display("[sorted_priority_queue_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned rand_cnt;
        int unsigned burst;
        int unsigned rem_pct;
        int unsigned k;
        req_t        r;

        // directed: underflow, extremes, ties, overflow, full drain
        pending_reqs.push_back(make_req(KIND_REMOVE, 32'sh1234_5678));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sd0));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sh7fff_ffff));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sh8000_0000));
        pending_reqs.push_back(make_req(KIND_INSERT, -32'sd1));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sd1));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sd7));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sd7));
        pending_reqs.push_back(make_req(KIND_INSERT, -32'sd7));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sd100));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sh7fff_ffff));
        for (k = 0; k < QUEUE_DEPTH; k++)
            pending_reqs.push_back(make_req(KIND_REMOVE, $urandom));
        pending_reqs.push_back(make_req(KIND_REMOVE, 32'shffff_ffff));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sh8000_0000));
        pending_reqs.push_back(make_req(KIND_REMOVE, 32'sd0));
        pending_reqs.push_back(make_req(KIND_INSERT, 32'sh7fff_ffff));
        pending_reqs.push_back(make_req(KIND_REMOVE, 32'sh7fff_ffff));

        // random: bursts that lean toward filling, draining, or neither
        rand_cnt = 0;
        while (rand_cnt < RAND_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       rem_pct = 20;
                1:       rem_pct = 80;
                default: rem_pct = 50;
            endcase
            burst = $urandom_range(4, 24);
            for (k = 0; k < burst; k++)
            begin
                r.kind  = ($urandom_range(0, 99) < rem_pct) ? KIND_REMOVE : KIND_INSERT;
                r.value = pick_value();
                pending_reqs.push_back(r);
                rand_cnt++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // poll once a cycle so queue sizes are always seen fresh
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d items: %0d ok, %0d overflow, %0d underflow, peak depth %0d",
                 items_taken, ok_cnt, ovf_cnt, unf_cnt, peak_occ);
        $display("checked %0d results with %0d mismatches", results_seen, error_cnt);
        if (error_cnt == 0)
            $display("[sorted_priority_queue_top] OK");
        else
            $display("[sorted_priority_queue_top] ERROR");
        $finish;
    end

endmodule
